// File: rtl/core/stli_pkg.sv
// Shared codes, command and status types for the sorted table interpolator.
package stli_pkg;

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_CLEAR  = 2'd1;
   localparam logic [1:0] REQ_QUERY  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_SAT   = 2'd3;

   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_RDVAL,
      SEL_INTERP
   } res_sel_type;

   typedef struct packed {
      logic        load_req;
      logic        clr_count;
      logic        inc_count;
      logic        idx_zero;
      logic        idx_count;
      logic        idx_inc;
      logic        idx_dec;
      logic        rd_en;
      logic        rd_below;
      logic        wr_shift;
      logic        wr_new;
      logic        save_prev;
      logic        brk_load;
      logic        mul_load;
      logic        div_step;
      logic        out_load;
      res_sel_type out_sel;
      logic [1:0]  out_status;
   } cmd_type;

   typedef struct packed {
      logic [1:0] req_kind;
      logic       empty;
      logic       full;
      logic       idx_is_zero;
      logic       idx_at_end;
      logic       key_eq;
      logic       key_gt;
      logic       div_done;
   } sts_type;

endpackage

// File: rtl/core/stli_ram.sv
// Generic single write port RAM with registered read.
module stli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/stli_datapath.sv
// Datapath: point memory, count and index, bracket registers, multiplier and serial divider.
module stli_datapath #(
   parameter int DEPTH = 32,
   parameter int KEY_W = 16,
   parameter int VAL_W = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              req_type,
   input  logic signed [KEY_W-1:0] x_value,
   input  logic signed [VAL_W-1:0] y_value,
   input  stli_pkg::cmd_type       cmd,
   output stli_pkg::sts_type       sts,
   output logic signed [VAL_W-1:0] y_result,
   output logic [1:0]              status
);

   localparam int AW  = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int PW  = KEY_W + VAL_W;
   localparam int DCW = $clog2(PW + 1);
   localparam logic [CW-1:0]  FULL_CNT = CW'(DEPTH);
   localparam logic [DCW-1:0] DIV_LEN  = DCW'(PW);
   localparam logic signed [VAL_W+1:0] SAT_HI = (VAL_W+2)'((64'd1 << (VAL_W - 1)) - 64'd1);
   localparam logic signed [VAL_W+1:0] SAT_LO = -SAT_HI - (VAL_W+2)'(1);

   logic [1:0]              kind_ff;
   logic signed [KEY_W-1:0] x_ff;
   logic signed [VAL_W-1:0] y_ff;
   logic [CW-1:0]           count_ff;
   logic [CW-1:0]           idx_ff;
   logic signed [KEY_W-1:0] prev_key_ff;
   logic signed [VAL_W-1:0] prev_val_ff;
   logic signed [VAL_W-1:0] y0_ff;
   logic                    neg_ff;
   logic [VAL_W-1:0]        mag_ff;
   logic [KEY_W-1:0]        dx_ff;
   logic [KEY_W-1:0]        bw_ff;
   logic [PW-1:0]           num_ff;
   logic [KEY_W-1:0]        rem_ff;
   logic [DCW-1:0]          dcnt_ff;
   logic signed [VAL_W-1:0] yout_ff;
   logic [1:0]              stout_ff;

   logic [KEY_W+VAL_W-1:0]  rd_data;
   logic [KEY_W+VAL_W-1:0]  wr_data;
   logic signed [KEY_W-1:0] rd_key;
   logic signed [VAL_W-1:0] rd_val;
   logic [CW-1:0]           raddr_full;
   logic signed [KEY_W:0]   dx_full;
   logic signed [KEY_W:0]   bw_full;
   logic signed [VAL_W:0]   dy_full;
   logic [VAL_W:0]          mag_full;
   logic [KEY_W:0]          shifted;
   logic                    qbit;
   logic signed [VAL_W+1:0] sum;
   logic                    sat;
   logic signed [VAL_W-1:0] sat_val;

   assign rd_key     = rd_data[KEY_W+VAL_W-1:VAL_W];
   assign rd_val     = rd_data[VAL_W-1:0];
   assign wr_data    = cmd.wr_new ? {x_ff, y_ff} : rd_data;
   assign raddr_full = cmd.rd_below ? idx_ff - CW'(1) : idx_ff;

   stli_ram #(
      .WIDTH(KEY_W + VAL_W),
      .DEPTH(DEPTH)
   ) u_points (
      .clock(clock),
      .we   (cmd.wr_new | cmd.wr_shift),
      .waddr(idx_ff[AW-1:0]),
      .wdata(wr_data),
      .re   (cmd.rd_en),
      .raddr(raddr_full[AW-1:0]),
      .rdata(rd_data)
   );

   assign dx_full  = (KEY_W+1)'(x_ff) - (KEY_W+1)'(prev_key_ff);
   assign bw_full  = (KEY_W+1)'(rd_key) - (KEY_W+1)'(prev_key_ff);
   assign dy_full  = (VAL_W+1)'(rd_val) - (VAL_W+1)'(prev_val_ff);
   assign mag_full = dy_full[VAL_W] ? (VAL_W+1)'(-dy_full) : dy_full;

   assign shifted = {rem_ff, num_ff[PW-1]};
   assign qbit    = shifted >= {1'b0, bw_ff};

   assign sum = neg_ff ? (VAL_W+2)'(y0_ff) - (VAL_W+2)'(num_ff[VAL_W-1:0])
                       : (VAL_W+2)'(y0_ff) + (VAL_W+2)'(num_ff[VAL_W-1:0]);
   always_comb begin
      sat     = 1'b0;
      sat_val = sum[VAL_W-1:0];
      if (sum > SAT_HI) begin
         sat     = 1'b1;
         sat_val = SAT_HI[VAL_W-1:0];
      end else if (sum < SAT_LO) begin
         sat     = 1'b1;
         sat_val = SAT_LO[VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.clr_count) begin
         count_ff <= '0;
      end else if (cmd.inc_count) begin
         count_ff <= count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff <= req_type;
         x_ff    <= x_value;
         y_ff    <= y_value;
      end
      if (cmd.idx_zero) begin
         idx_ff <= '0;
      end else if (cmd.idx_count) begin
         idx_ff <= count_ff;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + CW'(1);
      end else if (cmd.idx_dec) begin
         idx_ff <= idx_ff - CW'(1);
      end
      if (cmd.save_prev) begin
         prev_key_ff <= rd_key;
         prev_val_ff <= rd_val;
      end
      if (cmd.brk_load) begin
         y0_ff  <= prev_val_ff;
         neg_ff <= dy_full[VAL_W];
         mag_ff <= mag_full[VAL_W-1:0];
         dx_ff  <= dx_full[KEY_W-1:0];
         bw_ff  <= bw_full[KEY_W-1:0];
      end
      if (cmd.mul_load) begin
         num_ff  <= PW'(mag_ff * dx_ff);
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         num_ff  <= {num_ff[PW-2:0], qbit};
         rem_ff  <= qbit ? KEY_W'(shifted - {1'b0, bw_ff}) : shifted[KEY_W-1:0];
         dcnt_ff <= dcnt_ff + DCW'(1);
      end
      if (cmd.out_load) begin
         unique case (cmd.out_sel)
            stli_pkg::SEL_RDVAL: begin
               yout_ff  <= rd_val;
               stout_ff <= stli_pkg::ST_OK;
            end
            stli_pkg::SEL_INTERP: begin
               yout_ff  <= sat_val;
               stout_ff <= sat ? stli_pkg::ST_SAT : stli_pkg::ST_OK;
            end
            default: begin
               yout_ff  <= '0;
               stout_ff <= cmd.out_status;
            end
         endcase
      end
   end

   assign sts.req_kind    = kind_ff;
   assign sts.empty       = count_ff == '0;
   assign sts.full        = count_ff == FULL_CNT;
   assign sts.idx_is_zero = idx_ff == '0;
   assign sts.idx_at_end  = idx_ff == count_ff;
   assign sts.key_eq      = rd_key == x_ff;
   assign sts.key_gt      = rd_key > x_ff;
   assign sts.div_done    = dcnt_ff == DIV_LEN;

   assign y_result = yout_ff;
   assign status   = stout_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count above depth");
   a_no_insert_full: assert property (@(posedge clock) disable iff (reset)
      cmd.inc_count |-> !sts.full)
      else $error("insert into full table");
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_en || cmd.wr_new || cmd.wr_shift) |-> idx_ff <= count_ff)
      else $error("index beyond entry count");
   a_shift_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_shift |-> !sts.idx_is_zero)
      else $error("shift into slot zero");
`endif

endmodule

// File: rtl/core/stli_ctrl.sv
// Controller: request sequencing for insert, clear and query, result handshake.
module stli_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  stli_pkg::sts_type sts,
   output stli_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_INS_RD,
      S_INS_CMP,
      S_Q_RD,
      S_Q_CMP,
      S_Q_MUL,
      S_Q_DIV,
      S_FIN
   } state_type;

   state_type             state_ff, state_in;
   logic                  valid_ff, valid_in;
   stli_pkg::res_sel_type sel_ff, sel_in;
   logic [1:0]            fst_ff, fst_in;
   logic                  out_free;

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = valid_ff;
   assign out_free   = !valid_ff || rsp_tready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      sel_in   = sel_ff;
      fst_in   = fst_ff;
      valid_in = valid_ff && !rsp_tready;
      cmd.out_sel    = sel_ff;
      cmd.out_status = fst_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            sel_in   = stli_pkg::SEL_ZERO;
            fst_in   = stli_pkg::ST_OK;
            state_in = S_FIN;
            unique case (sts.req_kind)
               stli_pkg::REQ_INSERT: begin
                  if (sts.full) begin
                     fst_in = stli_pkg::ST_FULL;
                  end else begin
                     cmd.idx_count = 1'b1;
                     state_in      = S_INS_RD;
                  end
               end
               stli_pkg::REQ_CLEAR: begin
                  cmd.clr_count = 1'b1;
               end
               stli_pkg::REQ_QUERY: begin
                  if (sts.empty) begin
                     fst_in = stli_pkg::ST_RANGE;
                  end else begin
                     cmd.idx_zero = 1'b1;
                     state_in     = S_Q_RD;
                  end
               end
               default: begin
               end
            endcase
         end
         S_INS_RD: begin
            if (sts.idx_is_zero) begin
               cmd.wr_new    = 1'b1;
               cmd.inc_count = 1'b1;
               state_in      = S_FIN;
            end else begin
               cmd.rd_en    = 1'b1;
               cmd.rd_below = 1'b1;
               state_in     = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            if (sts.key_gt) begin
               cmd.wr_shift = 1'b1;
               cmd.idx_dec  = 1'b1;
               state_in     = S_INS_RD;
            end else begin
               cmd.wr_new    = 1'b1;
               cmd.inc_count = 1'b1;
               state_in      = S_FIN;
            end
         end
         S_Q_RD: begin
            if (sts.idx_at_end) begin
               fst_in   = stli_pkg::ST_RANGE;
               state_in = S_FIN;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_Q_CMP;
            end
         end
         S_Q_CMP: begin
            priority if (sts.key_eq) begin
               sel_in   = stli_pkg::SEL_RDVAL;
               state_in = S_FIN;
            end else if (sts.key_gt && sts.idx_is_zero) begin
               fst_in   = stli_pkg::ST_RANGE;
               state_in = S_FIN;
            end else if (sts.key_gt) begin
               cmd.brk_load = 1'b1;
               state_in     = S_Q_MUL;
            end else begin
               cmd.save_prev = 1'b1;
               cmd.idx_inc   = 1'b1;
               state_in      = S_Q_RD;
            end
         end
         S_Q_MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = S_Q_DIV;
         end
         S_Q_DIV: begin
            if (sts.div_done) begin
               sel_in   = stli_pkg::SEL_INTERP;
               state_in = S_FIN;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_FIN: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               valid_in     = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         sel_ff   <= stli_pkg::SEL_ZERO;
         fst_ff   <= stli_pkg::ST_OK;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
         fst_ff   <= fst_in;
      end
   end

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("accepted item while busy");
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> out_free)
      else $error("result overwritten before taken");
   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.out_load))
      else $error("result valid without load");
`endif

endmodule

// File: rtl/core/sorted_table_linear_interpolator.sv
// Top level: sorted point table with piecewise linear interpolation lookup.
// Insert: scans down from the end, shifting larger points up one slot, then writes the new point;
// clear or rejected item goes straight to the result. Query: scans up from index zero to the
// bracket at index i, then runs a bit-serial divide for the interpolated value.
// One item in work at a time; scan rate is set by the single read port of the table RAM.
// Synchronous active-high reset empties the table; no clearing pass is needed.
module sorted_table_linear_interpolator #(
   parameter int DEPTH = 32,
   parameter int KEY_W = 16,
   parameter int VAL_W = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // req_type[1:0], x_value[KEY_W-1:0], y_value[VAL_W-1:0], zero fill
   input  logic [((2 + KEY_W + VAL_W + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // y_result[VAL_W-1:0], status[1:0], zero fill
   output logic [((VAL_W + 2 + 7) / 8) * 8 - 1:0]    rsp_tdata
);

   localparam int OUT_W = ((VAL_W + 2 + 7) / 8) * 8;

   stli_pkg::cmd_type       cmd;
   stli_pkg::sts_type       sts;
   logic signed [VAL_W-1:0] y_result;
   logic [1:0]              status;

   stli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   stli_datapath #(
      .DEPTH(DEPTH),
      .KEY_W(KEY_W),
      .VAL_W(VAL_W)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .req_type(req_tdata[1:0]),
      .x_value (req_tdata[KEY_W+1:2]),
      .y_value (req_tdata[KEY_W+VAL_W+1:KEY_W+2]),
      .cmd     (cmd),
      .sts     (sts),
      .y_result(y_result),
      .status  (status)
   );

   assign rsp_tdata = OUT_W'({status, y_result});

endmodule

// File: tb/tb_checker.sv
// Checker: watches both channels, predicts the table lookup, compares results.
`timescale 1ns / 100ps
module tb_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] y_result;
   } lookup_rsp_type;

   logic signed [15:0] key_tab [32];
   logic signed [15:0] val_tab [32];
   int                 n_points;
   lookup_rsp_type     expected_q [$];
   int                 err_shown;

   function automatic lookup_rsp_type interp_lookup(input logic signed [15:0] x);
      lookup_rsp_type     r;
      int                 i;
      longint             x0, x1, y0, y1, dy, q, sum;
      r = '0;
      r.status = stli_pkg::ST_OK;
      if (n_points == 0 || x < key_tab[0] || x > key_tab[n_points-1]) begin
         r.status = stli_pkg::ST_RANGE;
         return r;
      end
      for (i = 0; i < n_points; i++) begin
         if (key_tab[i] == x) begin
            r.y_result = val_tab[i];
            return r;
         end
      end
      for (i = 1; i < n_points; i++) if (key_tab[i] > x) break;
      if (i >= n_points) begin
         r.status = stli_pkg::ST_RANGE;
         return r;
      end
      x0 = key_tab[i-1]; x1 = key_tab[i]; y0 = val_tab[i-1]; y1 = val_tab[i];
      dy = y1 - y0;
      q = ((dy < 0 ? -dy : dy) * (x - x0)) / (x1 - x0);
      sum = dy < 0 ? y0 - q : y0 + q;
      if (sum > 32767) begin sum = 32767; r.status = stli_pkg::ST_SAT; end
      if (sum < -32768) begin sum = -32768; r.status = stli_pkg::ST_SAT; end
      r.y_result = sum[15:0];
      return r;
   endfunction

   function automatic lookup_rsp_type table_apply(input logic [1:0] kind,
                                                  input logic signed [15:0] x,
                                                  input logic signed [15:0] y);
      lookup_rsp_type r;
      int             pos;
      r = '0;
      case (kind)
         stli_pkg::REQ_INSERT: begin
            if (n_points >= 32) r.status = stli_pkg::ST_FULL;
            else begin
               pos = 0;
               while (pos < n_points && key_tab[pos] <= x) pos++;
               for (int j = n_points; j > pos; j--) begin
                  key_tab[j] = key_tab[j-1];
                  val_tab[j] = val_tab[j-1];
               end
               key_tab[pos] = x;
               val_tab[pos] = y;
               n_points++;
            end
         end
         stli_pkg::REQ_CLEAR: n_points = 0;
         stli_pkg::REQ_QUERY: r = interp_lookup(x);
         default: ;
      endcase
      return r;
   endfunction

   assign pending = expected_q.size();

   always @(posedge clock) begin
      lookup_rsp_type got, want;
      if (reset) begin
         n_points   = 0;
         fail_count <= 0;
         err_shown  = 0;
         expected_q.delete();
      end else begin
         if (req_tvalid && req_tready)
            expected_q.insert(expected_q.size(),
                              table_apply(req_tdata[1:0], req_tdata[17:2],
                                          req_tdata[33:18]));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[17:0];
            if (expected_q.size() == 0) begin
               fail_count <= fail_count + 1;
               if (err_shown < 10) $display("unexpected item %h", got);
               err_shown++;
            end else begin
               want = expected_q.pop_front();
               if (got.y_result !== want.y_result || got.status !== want.status) begin
                  fail_count <= fail_count + 1;
                  if (err_shown < 10)
                     $display("mismatch: exp y=%h st=%0d, got y=%h st=%0d",
                              want.y_result, want.status, got.y_result, got.status);
                  err_shown++;
               end
            end
         end
      end
   end

endmodule

// File: tb/tb_top.sv
// Top: stimulus, clock, reset and verdict for the sorted table interpolator.
`timescale 1ns / 100ps
module tb_top;

   localparam logic [1:0] REQ_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   int          fail_count;
   int          pending;
   int          idle_cycles;
   bit          stall_go = 1'b0;
   bit          stall_done = 1'b0;
   bit          done = 1'b0;

   always #6 clock = ~clock;

   sorted_table_linear_interpolator i_dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   tb_checker i_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .fail_count, .pending
   );

   task automatic send_item(input logic [1:0] kind, input logic [15:0] x,
                            input logic [15:0] y);
      repeat ($urandom_range(0, 3)) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, y, x, kind};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // clear, random table fill, then mostly queries near its keys mixed with inserts and unused kinds
   task automatic build_and_probe(input int points);
      logic [15:0] base;
      int          span;
      base = 16'($urandom);
      span = $urandom_range(1, 2000);
      send_item(stli_pkg::REQ_CLEAR, 16'($urandom), 16'($urandom));
      for (int i = 0; i < points; i++)
         send_item(stli_pkg::REQ_INSERT, ($urandom_range(0, 7) == 0) ? 16'($urandom) :
                   16'(base + $urandom_range(0, span)), 16'($urandom));
      for (int i = 0; i < points * 2; i++) begin
         case ($urandom_range(0, 9))
            0: send_item(stli_pkg::REQ_QUERY, 16'($urandom), 16'($urandom));
            1: send_item(REQ_UNUSED, 16'($urandom), 16'($urandom));
            2: send_item(stli_pkg::REQ_INSERT, 16'(base + $urandom_range(0, span)),
                         16'($urandom));
            default: send_item(stli_pkg::REQ_QUERY, 16'(base + $urandom_range(0, span)),
                               16'($urandom));
         endcase
      end
   endtask

   // receiver: random gap per item, one long hold-off on request
   always begin : rsp_side
      int gap;
      @(negedge clock);
      if (stall_go && !stall_done) begin
         rsp_tready <= 1'b0;
         repeat (300) @(negedge clock);
         stall_done = 1'b1;
      end
      gap = $urandom_range(0, 3);
      rsp_tready <= 1'b0;
      repeat (gap) @(negedge clock);
      rsp_tready <= 1'b1;
      do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000 && !done) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed
      send_item(stli_pkg::REQ_QUERY, 16'h0000, 16'h0);
      send_item(stli_pkg::REQ_INSERT, 16'h8000, 16'h8000);
      send_item(stli_pkg::REQ_INSERT, 16'h7fff, 16'h7fff);
      send_item(stli_pkg::REQ_QUERY, 16'h0000, 16'h0);
      send_item(stli_pkg::REQ_QUERY, 16'h8000, 16'h0);
      send_item(stli_pkg::REQ_QUERY, 16'h7fff, 16'hffff);
      send_item(stli_pkg::REQ_INSERT, 16'h0010, 16'h1234);
      send_item(stli_pkg::REQ_INSERT, 16'h0010, 16'h4321);
      send_item(stli_pkg::REQ_QUERY, 16'h0010, 16'h0);
      send_item(stli_pkg::REQ_QUERY, 16'h0008, 16'h0);
      send_item(stli_pkg::REQ_QUERY, 16'hfff0, 16'h0);
      send_item(REQ_UNUSED, 16'hffff, 16'hffff);
      send_item(stli_pkg::REQ_CLEAR, 16'h0, 16'h0);
      send_item(stli_pkg::REQ_QUERY, 16'h0010, 16'h0);
      send_item(stli_pkg::REQ_INSERT, 16'h0005, 16'h0100);
      send_item(stli_pkg::REQ_QUERY, 16'h0006, 16'h0);
      send_item(stli_pkg::REQ_QUERY, 16'h0005, 16'h0);
      for (int i = 0; i < 33; i++)
         send_item(stli_pkg::REQ_INSERT, 16'(16'h7fff - i), 16'($urandom));
      send_item(stli_pkg::REQ_QUERY, 16'h7ff0, 16'h0);
      // pause until drained
      send_idle();
      wait (pending == 0);
      // long receiver stall while items keep coming
      stall_go = 1'b1;
      build_and_probe(4);
      repeat (45) build_and_probe($urandom_range(2, 34) > 30 ? 34 : $urandom_range(2, 20));
      send_idle();
      wait (pending == 0);
      repeat (150) @(posedge clock);
      done = 1'b1;
      if (fail_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
